// ----- sv/cau_pkg.sv -----
`default_nettype none
package cau_pkg;

	localparam int unsigned DATA_WIDTH_DEF = 32;
	localparam int unsigned FRAC_BITS_DEF  = 16;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		logic div;
		logic dz;
		logic ovf;
	} flags_t;

endpackage
`default_nettype wire

// ----- sv/complex_arith_unit_core.sv -----
// Complex-number ALU on signed fixed-point operands (Q16.16 by default).
// Input channel: in_valid/in_ready with operation (add, subtract, multiply,
// divide) and the operands a_re, a_im, b_re, b_im. Output channel:
// out_valid/out_ready with res_re, res_im, div_zero and overflow; one result
// word per input word, in order.
// Every operation runs through the same pipeline: four front stages
// (operand register, products, sums, sign/magnitude and divide setup), one
// restoring-divide stage per quotient bit (DATA_WIDTH+1 of them, each one
// wide compare and subtract for both parts), and an output register holding
// the final saturation. One word can enter every cycle while the receiver
// keeps taking results.
// Multiply and divide truncate toward zero; parts outside the range saturate
// and raise overflow. A divide by zero returns zero with div_zero set.
// Reset empties the pipeline. When the receiver stalls, each stage holds
// only while the stage after it is full, so bubbles close up and the
// pipeline keeps taking words until every stage is occupied.
`default_nettype none
module complex_arith_unit_core import cau_pkg::*; #(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            operation,
	input  wire logic [DATA_WIDTH-1:0] a_re,
	input  wire logic [DATA_WIDTH-1:0] a_im,
	input  wire logic [DATA_WIDTH-1:0] b_re,
	input  wire logic [DATA_WIDTH-1:0] b_im,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [DATA_WIDTH-1:0]      res_re,
	output logic [DATA_WIDTH-1:0]      res_im,
	output logic                       div_zero,
	output logic                       overflow
);

	localparam int unsigned W  = DATA_WIDTH;
	localparam int unsigned F  = FRAC_BITS;
	localparam int unsigned RW = 2 * W + F;
	localparam int unsigned FB = $bits(flags_t);
	localparam int unsigned SW = FB + 2 * W + 4;
	localparam int unsigned NS = W + 1;
	localparam logic [W-1:0] HALF_W = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MAXP_W = {1'b0, {(W-1){1'b1}}};

	logic           v    [0:NS];
	logic           rdy  [0:NS];
	logic [SW-1:0]  side [0:NS];
	logic [2*W-1:0] den  [0:NS];
	logic [RW-1:0]  rre  [0:NS];
	logic [RW-1:0]  rim  [0:NS];
	logic [W:0]     qre  [0:NS];
	logic [W:0]     qim  [0:NS];

	flags_t        f_front;
	logic [W-1:0]  re_front, im_front;
	logic          nre_front, nim_front, bre_front, bim_front;

	flags_t        f_c;
	logic [W-1:0]  fre_c, fim_c;
	logic          neg_re_c, neg_im_c, big_re_c, big_im_c;
	logic [W:0]    lim_re_c, lim_im_c;
	logic          o_re_c, o_im_c;
	logic [W-1:0]  mm_re_c, mm_im_c;

	logic          out_valid_q;
	logic          last_ready;

	cau_front #(.W(W), .F(F)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.a_re       (a_re),
		.a_im       (a_im),
		.b_re       (b_re),
		.b_im       (b_im),
		.out_valid  (v[0]),
		.out_ready  (rdy[0]),
		.out_flags  (f_front),
		.out_re     (re_front),
		.out_im     (im_front),
		.out_neg_re (nre_front),
		.out_neg_im (nim_front),
		.out_big_re (bre_front),
		.out_big_im (bim_front),
		.out_rem_re (rre[0]),
		.out_rem_im (rim[0]),
		.out_den    (den[0])
	);

	assign side[0] = {f_front, re_front, im_front, nre_front, nim_front, bre_front, bim_front};
	assign qre[0]  = '0;
	assign qim[0]  = '0;

	for (genvar j = 0; j < NS; j++) begin : g_div
		cau_div_step #(.W(W), .F(F), .K(W - j), .SW(SW)) u_step (
			.clk        (clk),
			.arst_n     (arst_n),
			.in_valid   (v[j]),
			.in_ready   (rdy[j]),
			.in_side    (side[j]),
			.in_den     (den[j]),
			.in_rem_re  (rre[j]),
			.in_rem_im  (rim[j]),
			.in_q_re    (qre[j]),
			.in_q_im    (qim[j]),
			.out_valid  (v[j+1]),
			.out_ready  (rdy[j+1]),
			.out_side   (side[j+1]),
			.out_den    (den[j+1]),
			.out_rem_re (rre[j+1]),
			.out_rem_im (rim[j+1]),
			.out_q_re   (qre[j+1]),
			.out_q_im   (qim[j+1])
		);
	end

	assign last_ready = !out_valid_q || out_ready;
	assign rdy[NS]    = last_ready;

	always_comb begin
		{f_c, fre_c, fim_c, neg_re_c, neg_im_c, big_re_c, big_im_c} = side[NS];
		lim_re_c = {1'b0, (neg_re_c ? HALF_W : MAXP_W)};
		lim_im_c = {1'b0, (neg_im_c ? HALF_W : MAXP_W)};
		o_re_c   = big_re_c || (qre[NS] > lim_re_c);
		o_im_c   = big_im_c || (qim[NS] > lim_im_c);
		mm_re_c  = o_re_c ? lim_re_c[W-1:0] : qre[NS][W-1:0];
		mm_im_c  = o_im_c ? lim_im_c[W-1:0] : qim[NS][W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (last_ready) begin
			out_valid_q <= v[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (last_ready && v[NS]) begin
			div_zero <= f_c.dz;
			if (f_c.div) begin
				res_re   <= neg_re_c ? -mm_re_c : mm_re_c;
				res_im   <= neg_im_c ? -mm_im_c : mm_im_c;
				overflow <= o_re_c || o_im_c;
			end else begin
				res_re   <= fre_c;
				res_im   <= fim_c;
				overflow <= f_c.ovf;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_zero |-> res_re == '0 && res_im == '0 && !overflow)
		else $error("divide by zero result not cleared");

	a_ovf_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |->
			res_re == HALF_W || res_re == MAXP_W || res_im == HALF_W || res_im == MAXP_W)
		else $error("overflow without a saturated part");

	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("pipeline stalled without output backpressure");

endmodule
`default_nettype wire

// ----- sv/cau_front.sv -----
`default_nettype none
module cau_front import cau_pkg::*; #(
	parameter int unsigned W = DATA_WIDTH_DEF,
	parameter int unsigned F = FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        operation,
	input  wire logic [W-1:0]      a_re,
	input  wire logic [W-1:0]      a_im,
	input  wire logic [W-1:0]      b_re,
	input  wire logic [W-1:0]      b_im,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output flags_t                 out_flags,
	output logic [W-1:0]           out_re,
	output logic [W-1:0]           out_im,
	output logic                   out_neg_re,
	output logic                   out_neg_im,
	output logic                   out_big_re,
	output logic                   out_big_im,
	output logic [2*W+F-1:0]       out_rem_re,
	output logic [2*W+F-1:0]       out_rem_im,
	output logic [2*W-1:0]         out_den
);

	localparam int unsigned PW = 2 * W;
	localparam int unsigned RW = 2 * W + F;
	localparam int unsigned CW = RW + W + 1;
	localparam logic [W-1:0] HALF_W = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MAXP_W = {1'b0, {(W-1){1'b1}}};

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	op_t op_s1, op_s2, op_s3;
	logic signed [W-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	logic signed [PW-1:0] rr_s2, ii_s2, ri_s2, ir_s2, sqr_s2, sqi_s2;
	logic signed [W:0]    sre_s2, sim_s2;

	logic signed [PW:0] acc_re_s3, acc_im_s3;
	logic [PW-1:0]      den_s3;
	logic [W-1:0]       as_re_s3, as_im_s3;
	logic               as_ovf_s3;

	logic signed [PW:0] acc_re_c, acc_im_c;
	logic [W-1:0]       as_re_c, as_im_c;
	logic               as_ovf_re, as_ovf_im;

	logic               neg_re_c, neg_im_c;
	logic [PW:0]        abs_re_c, abs_im_c;
	logic [PW-1:0]      mag_re_c, mag_im_c, m_re_c, m_im_c, lim_re_c, lim_im_c;
	logic               mo_re_c, mo_im_c;
	logic [W-1:0]       mm_re_c, mm_im_c;
	logic [RW-1:0]      x_re_c, x_im_c;
	logic [CW-1:0]      dlim_c;
	logic               dz_c;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			op_s1 <= op_t'(operation);
			ar_s1 <= a_re;
			ai_s1 <= a_im;
			br_s1 <= b_re;
			bi_s1 <= b_im;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			op_s2  <= op_s1;
			rr_s2  <= ar_s1 * br_s1;
			ii_s2  <= ai_s1 * bi_s1;
			ri_s2  <= ar_s1 * bi_s1;
			ir_s2  <= ai_s1 * br_s1;
			sqr_s2 <= br_s1 * br_s1;
			sqi_s2 <= bi_s1 * bi_s1;
			if (op_s1 == OP_SUB) begin
				sre_s2 <= {ar_s1[W-1], ar_s1} - {br_s1[W-1], br_s1};
				sim_s2 <= {ai_s1[W-1], ai_s1} - {bi_s1[W-1], bi_s1};
			end else begin
				sre_s2 <= {ar_s1[W-1], ar_s1} + {br_s1[W-1], br_s1};
				sim_s2 <= {ai_s1[W-1], ai_s1} + {bi_s1[W-1], bi_s1};
			end
		end
	end

	always_comb begin
		if (op_s2 == OP_MUL) begin
			acc_re_c = {rr_s2[PW-1], rr_s2} - {ii_s2[PW-1], ii_s2};
			acc_im_c = {ri_s2[PW-1], ri_s2} + {ir_s2[PW-1], ir_s2};
		end else begin
			acc_re_c = {rr_s2[PW-1], rr_s2} + {ii_s2[PW-1], ii_s2};
			acc_im_c = {ir_s2[PW-1], ir_s2} - {ri_s2[PW-1], ri_s2};
		end
		as_ovf_re = sre_s2[W] != sre_s2[W-1];
		as_ovf_im = sim_s2[W] != sim_s2[W-1];
		as_re_c   = as_ovf_re ? (sre_s2[W] ? HALF_W : MAXP_W) : sre_s2[W-1:0];
		as_im_c   = as_ovf_im ? (sim_s2[W] ? HALF_W : MAXP_W) : sim_s2[W-1:0];
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			op_s3     <= op_s2;
			acc_re_s3 <= acc_re_c;
			acc_im_s3 <= acc_im_c;
			den_s3    <= sqr_s2 + sqi_s2;
			as_re_s3  <= as_re_c;
			as_im_s3  <= as_im_c;
			as_ovf_s3 <= as_ovf_re || as_ovf_im;
		end
	end

	always_comb begin
		neg_re_c = acc_re_s3[PW];
		neg_im_c = acc_im_s3[PW];
		abs_re_c = neg_re_c ? -acc_re_s3 : acc_re_s3;
		abs_im_c = neg_im_c ? -acc_im_s3 : acc_im_s3;
		mag_re_c = abs_re_c[PW-1:0];
		mag_im_c = abs_im_c[PW-1:0];
		m_re_c   = mag_re_c >> F;
		m_im_c   = mag_im_c >> F;
		lim_re_c = {{W{1'b0}}, (neg_re_c ? HALF_W : MAXP_W)};
		lim_im_c = {{W{1'b0}}, (neg_im_c ? HALF_W : MAXP_W)};
		mo_re_c  = m_re_c > lim_re_c;
		mo_im_c  = m_im_c > lim_im_c;
		mm_re_c  = mo_re_c ? lim_re_c[W-1:0] : m_re_c[W-1:0];
		mm_im_c  = mo_im_c ? lim_im_c[W-1:0] : m_im_c[W-1:0];
		x_re_c   = RW'(mag_re_c) << F;
		x_im_c   = RW'(mag_im_c) << F;
		dlim_c   = CW'(den_s3) << (W + 1);
		dz_c     = den_s3 == '0;
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			out_flags.div   <= (op_s3 == OP_DIV) && !dz_c;
			out_flags.dz    <= (op_s3 == OP_DIV) && dz_c;
			out_neg_re      <= neg_re_c;
			out_neg_im      <= neg_im_c;
			out_big_re      <= CW'(x_re_c) >= dlim_c;
			out_big_im      <= CW'(x_im_c) >= dlim_c;
			out_rem_re      <= x_re_c;
			out_rem_im      <= x_im_c;
			out_den         <= den_s3;
			case (op_s3)
				OP_ADD, OP_SUB: begin
					out_re        <= as_re_s3;
					out_im        <= as_im_s3;
					out_flags.ovf <= as_ovf_s3;
				end
				OP_MUL: begin
					out_re        <= neg_re_c ? -mm_re_c : mm_re_c;
					out_im        <= neg_im_c ? -mm_im_c : mm_im_c;
					out_flags.ovf <= mo_re_c || mo_im_c;
				end
				default: begin
					out_re        <= '0;
					out_im        <= '0;
					out_flags.ovf <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid = v_s4;

endmodule
`default_nettype wire

// ----- sv/cau_div_step.sv -----
`default_nettype none
module cau_div_step import cau_pkg::*; #(
	parameter int unsigned W  = DATA_WIDTH_DEF,
	parameter int unsigned F  = FRAC_BITS_DEF,
	parameter int unsigned K  = 0,
	parameter int unsigned SW = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [SW-1:0]     in_side,
	input  wire logic [2*W-1:0]    in_den,
	input  wire logic [2*W+F-1:0]  in_rem_re,
	input  wire logic [2*W+F-1:0]  in_rem_im,
	input  wire logic [W:0]        in_q_re,
	input  wire logic [W:0]        in_q_im,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [SW-1:0]          out_side,
	output logic [2*W-1:0]         out_den,
	output logic [2*W+F-1:0]       out_rem_re,
	output logic [2*W+F-1:0]       out_rem_im,
	output logic [W:0]             out_q_re,
	output logic [W:0]             out_q_im
);

	localparam int unsigned RW = 2 * W + F;
	localparam int unsigned CW = RW + W + 1;

	logic          v_q;
	logic [CW-1:0] dsh, diff_re, diff_im;
	logic          ge_re, ge_im;

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;

	always_comb begin
		dsh     = CW'(in_den) << K;
		ge_re   = CW'(in_rem_re) >= dsh;
		ge_im   = CW'(in_rem_im) >= dsh;
		diff_re = CW'(in_rem_re) - dsh;
		diff_im = CW'(in_rem_im) - dsh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_side   <= in_side;
			out_den    <= in_den;
			out_rem_re <= ge_re ? diff_re[RW-1:0] : in_rem_re;
			out_rem_im <= ge_im ? diff_im[RW-1:0] : in_rem_im;
			out_q_re   <= {in_q_re[W-1:0], ge_re};
			out_q_im   <= {in_q_im[W-1:0], ge_im};
		end
	end

endmodule
`default_nettype wire

// ----- test/complex_arith_unit_core_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module complex_arith_unit_core_tb;
	import cau_pkg::*;

	localparam int ONE = 32'h0001_0000;
	localparam int MAXV = 32'h7fff_ffff;
	localparam int MINV = 32'h8000_0000;
	localparam int RAND_ITEMS = 1880;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 80;
	localparam int STALL_CYCLES = 600;

	typedef struct {
		logic [31:0] re;
		logic [31:0] im;
		logic dz;
		logic ovf;
	} cplx_result_t;

	typedef struct {
		op_t op;
		logic [31:0] ar, ai, br, bi;
		bit known;
		cplx_result_t res;
	} vector_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] operation = '0;
	logic [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [31:0] res_re, res_im;
	logic div_zero, overflow;

	cplx_result_t pending_results[$];
	bit failed = 0;
	bit stim_done = 0;
	int idle_cycles = 0;
	int results_seen = 0;
	bit idle_on = 1;

	complex_arith_unit_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.out_valid(out_valid), .out_ready(out_ready),
		.res_re(res_re), .res_im(res_im), .div_zero(div_zero), .overflow(overflow)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] clamp(input bit neg, input logic [127:0] mag,
			inout logic ovf);
		logic [127:0] lim;
		lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
		if (mag > lim) begin
			ovf = 1;
			mag = lim;
		end
		return neg ? (~mag[31:0] + 32'd1) : mag[31:0];
	endfunction

	function automatic logic [127:0] magn(input logic signed [127:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic cplx_result_t compute_result(input op_t op,
			input logic [31:0] ar, ai, br, bi);
		logic signed [127:0] xr, xi, yr, yi, sr, si, den;
		logic [127:0] mr, mi;
		cplx_result_t r;
		xr = {{96{ar[31]}}, ar};
		xi = {{96{ai[31]}}, ai};
		yr = {{96{br[31]}}, br};
		yi = {{96{bi[31]}}, bi};
		r.dz = 0;
		r.ovf = 0;
		case (op)
			OP_ADD: begin
				sr = xr + yr;
				si = xi + yi;
				mr = magn(sr);
				mi = magn(si);
			end
			OP_SUB: begin
				sr = xr - yr;
				si = xi - yi;
				mr = magn(sr);
				mi = magn(si);
			end
			OP_MUL: begin
				sr = xr * yr - xi * yi;
				si = xr * yi + xi * yr;
				mr = magn(sr) >> 16;
				mi = magn(si) >> 16;
			end
			default: begin
				den = yr * yr + yi * yi;
				sr = xr * yr + xi * yi;
				si = xi * yr - xr * yi;
				if (den == 0) begin
					r.dz = 1;
					sr = 0;
					si = 0;
					mr = 0;
					mi = 0;
				end else begin
					mr = (magn(sr) << 16) / den;
					mi = (magn(si) << 16) / den;
				end
			end
		endcase
		r.re = clamp(sr < 0, mr, r.ovf);
		r.im = clamp(si < 0, mi, r.ovf);
		return r;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return MAXV;
			1: return MINV;
			2: return '0;
			3: return $urandom_range(0, 8) << 16;
			4: return -($urandom_range(0, 8) << 16);
			5: return $signed($urandom_range(0, 32'h0007_ffff)) - 32'sh0004_0000;
			default: return $urandom;
		endcase
	endfunction

	vector_t directed[] = '{
		'{OP_ADD, 0, 0, 0, 0, 1, '{32'h0, 32'h0, 0, 0}},
		'{OP_ADD, MAXV, MAXV, MAXV, MINV, 1, '{MAXV, 32'hffff_ffff, 0, 1}},
		'{OP_ADD, MINV, MINV, MINV, MAXV, 1, '{MINV, 32'hffff_ffff, 0, 1}},
		'{OP_SUB, MINV, MAXV, ONE, MINV, 1, '{MINV, MAXV, 0, 1}},
		'{OP_SUB, MAXV, 0, MAXV, 0, 1, '{32'h0, 32'h0, 0, 0}},
		'{OP_MUL, ONE, 0, ONE, 0, 1, '{ONE, 32'h0, 0, 0}},
		'{OP_MUL, 0, ONE, 0, ONE, 1, '{-ONE, 32'h0, 0, 0}},
		'{OP_MUL, MAXV, MAXV, MAXV, MAXV, 0, '{0, 0, 0, 0}},
		'{OP_MUL, MINV, MINV, MINV, MINV, 0, '{0, 0, 0, 0}},
		'{OP_MUL, MINV, 0, MINV, 0, 1, '{MAXV, 32'h0, 0, 1}},
		'{OP_MUL, 32'hffff_ffff, 0, 1, 0, 0, '{0, 0, 0, 0}},
		'{OP_DIV, ONE, ONE, 0, 0, 1, '{32'h0, 32'h0, 1, 0}},
		'{OP_DIV, MAXV, MINV, 0, 0, 1, '{32'h0, 32'h0, 1, 0}},
		'{OP_DIV, ONE, 0, ONE, 0, 1, '{ONE, 32'h0, 0, 0}},
		'{OP_DIV, MAXV, MAXV, 1, 0, 1, '{MAXV, MAXV, 0, 1}},
		'{OP_DIV, MINV, MINV, 1, 0, 1, '{MINV, MINV, 0, 1}},
		'{OP_DIV, MINV, MAXV, MINV, MINV, 0, '{0, 0, 0, 0}},
		'{OP_DIV, 3, 5, 0, 1, 0, '{0, 0, 0, 0}},
		'{OP_DIV, -7, 11, 3 * ONE, -ONE, 0, '{0, 0, 0, 0}},
		'{OP_DIV, ONE, 0, MAXV, MAXV, 0, '{0, 0, 0, 0}}
	};

	task automatic send_word(input op_t op, input logic [31:0] ar, ai, br, bi,
			input cplx_result_t res);
		int gap;
		gap = idle_on ? $urandom_range(0, 10) : 0;
		repeat (gap) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		operation = op;
		a_re = ar;
		a_im = ai;
		b_re = br;
		b_im = bi;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(res);
		@(negedge clk);
	endtask

	initial begin
		op_t op;
		logic [31:0] ar, ai, br, bi;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		foreach (directed[i]) begin
			vector_t v;
			v = directed[i];
			send_word(v.op, v.ar, v.ai, v.br, v.bi,
				v.known ? v.res : compute_result(v.op, v.ar, v.ai, v.br, v.bi));
		end
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 100 == 0)
				idle_on = $urandom_range(0, 3) != 0;
			op = op_t'($urandom_range(0, 3));
			ar = rand_operand();
			ai = rand_operand();
			br = rand_operand();
			bi = rand_operand();
			if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
				br = 0;
				bi = 0;
			end
			send_word(op, ar, ai, br, bi, compute_result(op, ar, ai, br, bi));
		end
		in_valid = 0;
		stim_done = 1;
	end

	initial begin
		int gap;
		bit stalled;
		stalled = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!stalled && results_seen >= 40) begin
				stalled = 1;
				out_ready = 0;
				repeat (STALL_CYCLES) @(negedge clk);
			end
			gap = idle_on ? $urandom_range(0, 10) : 0;
			if (gap > 0) begin
				out_ready = 0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			cplx_result_t e;
			results_seen <= results_seen + 1;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result re=%h im=%h", $time, res_re, res_im);
				failed = 1;
			end else begin
				e = pending_results.pop_front();
				if (res_re !== e.re || res_im !== e.im || div_zero !== e.dz
						|| overflow !== e.ovf) begin
					$display("%0t: mismatch expected re=%h im=%h dz=%b ovf=%b",
						$time, e.re, e.im, e.dz, e.ovf);
					$display("%0t:          actual   re=%h im=%h dz=%b ovf=%b",
						$time, res_re, res_im, div_zero, overflow);
					failed = 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (stim_done && pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
